@@ hw/rtl/ect_pkg.sv @@
package ect_pkg;

    // default sizes of the table
    localparam int RULES_DEF       = 64;
    localparam int MAX_CLASSES_DEF = 256;

    // fixed field widths
    localparam int MAP_W   = 64;
    localparam int ID_W    = 8;
    localparam int BEST_W  = 7;
    localparam int CHUNK_W = 8;
    localparam int OUT_W   = 24;

    // command codes carried in the request selector
    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_CLEAR    = 1'b1;

    // control from the sequencer to the lowest-bit finder
    typedef struct packed {
        logic start;
    } lb_ctl_t;

    // status back from the lowest-bit finder
    typedef struct packed {
        logic              done;
        logic [BEST_W-1:0] best;
    } lb_stat_t;

endpackage

@@ hw/rtl/ect_store.sv @@
module ect_store
    import ect_pkg::*;
#(
    parameter int DEPTH = MAX_CLASSES_DEF,
    parameter int WIDTH = RULES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ect_lowbit.sv @@
module ect_lowbit
    import ect_pkg::*;
#(
    parameter int RULES = RULES_DEF,
    localparam int NCH  = (RULES + CHUNK_W - 1) / CHUNK_W,
    localparam int KW   = (NCH > 1) ? $clog2(NCH) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lb_ctl_t          ctl,
    input  logic [RULES-1:0] map,
    output lb_stat_t         stat
);

    logic                   busy_reg, busy_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [NCH*CHUNK_W-1:0] map_reg, map_next;
    logic                   done_reg, done_next;
    logic [BEST_W-1:0]      best_reg, best_next;
    logic [CHUNK_W-1:0]     chunk;
    logic [2:0]             pe;

    // one byte of the bitmap examined per cycle
    assign chunk = map_reg[k_reg*CHUNK_W +: CHUNK_W];

    // priority encoder over the current byte
    always_comb
    begin
        pe = 3'd0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            if (chunk[i])
            begin
                pe = 3'(i);
            end
        end
    end

    // search sequencer
    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        map_next  = map_reg;
        done_next = 1'b0;
        best_next = best_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            map_next  = (NCH*CHUNK_W)'(map);
        end
        else if (busy_reg)
        begin
            if (chunk != '0)
            begin
                best_next = (BEST_W'(k_reg) << 3) + BEST_W'(pe) + BEST_W'(1);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (k_reg == KW'(NCH - 1))
            begin
                best_next = '0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        map_reg  <= map_next;
        best_reg <= best_next;
    end

    assign stat.done = done_reg;
    assign stat.best = best_reg;

endmodule

@@ hw/rtl/equivalence_class_table.sv @@
// channel  | direction | tdata                    | tuser
// ---------+-----------+--------------------------+-----------
// s_axis   | in        | match_map[63:0]          | cmd[0]
// m_axis   | out       | class_id, is_new,        | none
//          |           | table_full, best_rule    |
//
// a classify request first finds the lowest set bit one byte a cycle, then the
// stored classes are read one entry a cycle through the single read port of the
// class memory and checked by one comparator; a clear request goes straight to
// the output state.
// reset empties the table (count only, no memory pass) and drops any result.
// a stalled result is held in the output register; the next request can be
// taken meanwhile but its result waits until the register is free.
module equivalence_class_table
    import ect_pkg::*;
#(
    parameter int RULES       = RULES_DEF,
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [MAP_W-1:0] s_tdata,   // match_map[63:0]
    input  logic [0:0]       s_tuser,   // cmd[0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // class_id[7:0], is_new[8], table_full[9],
                                        // best_rule[16:10], zero[23:17]
);

    localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CW = $clog2(MAX_CLASSES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOWB = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     issue_reg, issue_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [RULES-1:0]  map_reg, map_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic              res_new_reg, res_new_next;
    logic              res_full_reg, res_full_next;
    logic [BEST_W-1:0] res_best_reg, res_best_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    logic              accept;
    logic              mem_we;
    logic              mem_re;
    logic [RULES-1:0]  mem_rdata;
    lb_ctl_t           lb_ctl;
    lb_stat_t          lb_stat;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // class memory
    ect_store #(
        .DEPTH (MAX_CLASSES),
        .WIDTH (RULES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (map_reg),
        .re    (mem_re),
        .raddr (issue_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    // lowest set rule finder
    assign lb_ctl.start = accept && (s_tuser[0] == CMD_CLASSIFY);

    ect_lowbit #(
        .RULES (RULES)
    ) u_lowbit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (lb_ctl),
        .map   (s_tdata[RULES-1:0]),
        .stat  (lb_stat)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        rd_valid_next = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        map_next      = map_reg;
        res_id_next   = res_id_reg;
        res_new_next  = res_new_reg;
        res_full_next = res_full_reg;
        res_best_next = res_best_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    map_next = s_tdata[RULES-1:0];
                    if (s_tuser[0] == CMD_CLEAR)
                    begin
                        count_next    = '0;
                        res_id_next   = '0;
                        res_new_next  = 1'b0;
                        res_full_next = 1'b0;
                        res_best_next = '0;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        state_next = S_LOWB;
                    end
                end
            end
            S_LOWB:
            begin
                if (lb_stat.done)
                begin
                    res_best_next = lb_stat.best;
                    issue_next    = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one stored class compared per cycle, reads run one ahead
                if (rd_valid_reg && (mem_rdata == map_reg))
                begin
                    res_id_next   = ID_W'(cmp_idx_reg);
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    state_next    = S_OUT;
                end
                else if (issue_reg < count_reg)
                begin
                    mem_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    cmp_idx_next  = issue_reg[AW-1:0];
                    issue_next    = issue_reg + CW'(1);
                end
                else if (count_reg < CW'(MAX_CLASSES))
                begin
                    mem_we        = 1'b1;
                    res_id_next   = ID_W'(count_reg);
                    res_new_next  = 1'b1;
                    res_full_next = 1'b0;
                    count_next    = count_reg + CW'(1);
                    state_next    = S_OUT;
                end
                else
                begin
                    res_id_next   = '0;
                    res_new_next  = 1'b0;
                    res_full_next = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_W'({res_best_reg, res_full_reg, res_new_reg,
                                           res_id_reg});
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        map_reg      <= map_next;
        res_id_reg   <= res_id_next;
        res_new_reg  <= res_new_next;
        res_full_reg <= res_full_next;
        res_best_reg <= res_best_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // class count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_CLASSES))
        else $error("class count above table size");

    // an append only happens while a free entry is left
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (count_reg < CW'(MAX_CLASSES)))
        else $error("class memory written with table full");

    // a clear request empties the table
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser[0] == CMD_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty table");

    // a result is never both new and full
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_data_reg[ID_W] && m_data_reg[ID_W+1]))
        else $error("result flagged both new and full");

endmodule
